[sv/udg_pkg.sv]
package udg_pkg;

    // request and event codes carried in the slave-side tuser
    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RX_BYTE = 2'd2,
        FUNC_TICK    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_FRAME   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // register indexes on the config port (paddr[3:2])
    localparam logic [1:0] CFG_SYNC    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    localparam logic [7:0] SYNC_RESET    = 8'd5;
    localparam logic [7:0] TIMEOUT_RESET = 8'd30;
    localparam logic [5:0] LIMIT_RESET   = 6'd32;

    localparam int         RX_BUFFER_BYTES = 32;
    localparam logic [6:0] RX_MIN_BYTES    = 7'd8;
    localparam logic [6:0] RX_MAX_BYTES    = 7'(RX_BUFFER_BYTES);

    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] REG_WRITE_FLAG = 8'h80;
    localparam logic [7:0] REPLY_ADDR     = 8'hFF;
    localparam logic [7:0] TICK_SAT       = 8'hFF;

    localparam int         FRAME_BYTES = 8;
    localparam logic [3:0] WRITE_LEN   = 4'd8;
    localparam logic [3:0] READ_LEN    = 4'd4;

    typedef struct packed {
        logic  step;
        func_t func;
    } rx_ctrl_t;

    typedef struct packed {
        logic        done;
        status_t     status;
        logic [31:0] value;
    } rx_result_t;

    // one byte into the crc, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++)
        begin
            if (crc[7] ^ data[b])
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

    // crc of seven bytes, first byte in the top bits
    function automatic logic [7:0] crc8_7(input logic [55:0] msg);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 6; i >= 0; i--)
        begin
            crc = crc8_byte(crc, msg[i*8 +: 8]);
        end
        return crc;
    endfunction

endpackage

[sv/udg_rx.sv]
module udg_rx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  udg_pkg::rx_ctrl_t     ctrl,
    input  logic [6:0]            reg_addr,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            sync_byte,
    input  logic [7:0]            reply_timeout_ms,
    input  logic [5:0]            rx_byte_limit,
    output udg_pkg::rx_result_t   result
);

    logic [63:0] window_reg, window_next;
    logic [5:0]  count_reg, count_next;
    logic [7:0]  elapsed_reg, elapsed_next;
    logic [6:0]  pending_reg, pending_next;
    logic        awaiting_reg, awaiting_next;

    logic [63:0] win_shift;
    logic [5:0]  count_inc;
    logic [7:0]  elapsed_inc;
    logic [6:0]  limit;
    logic        header_match;
    logic        crc_ok;

    assign win_shift   = {window_reg[55:0], rx_byte};
    assign count_inc   = count_reg + 6'd1;
    assign elapsed_inc = (elapsed_reg == udg_pkg::TICK_SAT) ? elapsed_reg : elapsed_reg + 8'd1;

    // byte limit clamped to the window size and the buffer size
    always_comb
    begin
        if ({1'b0, rx_byte_limit} < udg_pkg::RX_MIN_BYTES)
            limit = udg_pkg::RX_MIN_BYTES;
        else if ({1'b0, rx_byte_limit} > udg_pkg::RX_MAX_BYTES)
            limit = udg_pkg::RX_MAX_BYTES;
        else
            limit = {1'b0, rx_byte_limit};
    end

    assign header_match = ({1'b0, count_inc} >= udg_pkg::RX_MIN_BYTES)
                       && (win_shift[63:56] == sync_byte)
                       && (win_shift[55:48] == udg_pkg::REPLY_ADDR)
                       && (win_shift[46:40] == pending_reg);
    assign crc_ok = (udg_pkg::crc8_7(win_shift[63:8]) == win_shift[7:0]);

    always_comb
    begin
        window_next   = window_reg;
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        pending_next  = pending_reg;
        awaiting_next = awaiting_reg;
        result        = '0;
        if (ctrl.step)
        begin
            unique case (ctrl.func)
                udg_pkg::FUNC_WRITE, udg_pkg::FUNC_READ:
                begin
                    window_next   = '0;
                    count_next    = '0;
                    elapsed_next  = '0;
                    awaiting_next = (ctrl.func == udg_pkg::FUNC_READ);
                    if (ctrl.func == udg_pkg::FUNC_READ)
                        pending_next = reg_addr;
                end
                udg_pkg::FUNC_RX_BYTE:
                begin
                    if (awaiting_reg)
                    begin
                        window_next = win_shift;
                        count_next  = count_inc;
                        if (header_match)
                        begin
                            result.done   = 1'b1;
                            result.status = crc_ok ? udg_pkg::ST_OK : udg_pkg::ST_CRC;
                            result.value  = crc_ok ? win_shift[39:8] : 32'd0;
                            awaiting_next = 1'b0;
                        end
                        else if ({1'b0, count_inc} >= limit)
                        begin
                            result.done   = 1'b1;
                            result.status = udg_pkg::ST_FRAME;
                            awaiting_next = 1'b0;
                        end
                    end
                end
                udg_pkg::FUNC_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= reply_timeout_ms)
                        begin
                            result.done   = 1'b1;
                            result.status = (count_reg == 6'd0) ? udg_pkg::ST_TIMEOUT
                                                                : udg_pkg::ST_FRAME;
                            awaiting_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    awaiting_next = awaiting_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            count_reg    <= '0;
            elapsed_reg  <= '0;
            pending_reg  <= '0;
            awaiting_reg <= 1'b0;
        end
        else
        begin
            window_reg   <= window_next;
            count_reg    <= count_next;
            elapsed_reg  <= elapsed_next;
            pending_reg  <= pending_next;
            awaiting_reg <= awaiting_next;
        end
    end

    // a completion only comes out of armed reception
    a_done_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> awaiting_reg)
        else $error("completion while reception not armed");

    // completion always disarms
    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |=> !awaiting_reg)
        else $error("reception still armed after completion");

    // armed reception never counts up to the buffer size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> ({1'b0, count_reg} < udg_pkg::RX_MAX_BYTES))
        else $error("reception count reached the buffer size while armed");

endmodule

[sv/uart_register_datagram_engine_core.sv]
// an item is registered on accept, then handed over to the frame buffer that drives the output
// throughput: a write request holds the input while its 8 bytes leave, a read request while its
//   4; one per cycle for received bytes and ticks while the output is not stalled by m_tready
// the next item is accepted while the current frame drains, handed over on its last byte
// reset: rst_n asynchronous active low; config back to sync 5, timeout 30, limit 32,
//   reception disarmed with window, counters and pending register cleared
module uart_register_datagram_engine_core (
    input  logic        clk,
    input  logic        rst_n,

    // item input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // node_addr[1:0], reg_addr[8:2], write_value[40:9],
                                   // rx_byte[48:41], zero fill [55:49]
    input  logic [1:0]  s_tuser,   // func[1:0]

    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_byte[7:0], status[9:8], read_value[41:10],
                                   // zero fill [47:42]
    output logic        m_tuser,   // kind
    output logic        m_tlast,   // last

    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic [7:0] sync_reg;
    logic [7:0] timeout_reg;
    logic [5:0] limit_reg;
    logic       cfg_write;

    // input register
    logic            in_valid_reg, in_valid_next;
    udg_pkg::func_t  in_func_reg;
    logic [1:0]      in_node_reg;
    logic [6:0]      in_reg_reg;
    logic [31:0]     in_wval_reg;
    logic [7:0]      in_rxb_reg;

    // frame buffer feeding the output, byte 0 is the one on the bus
    logic [3:0]      cnt_reg, cnt_next;
    logic            kind_reg;
    udg_pkg::status_t status_reg;
    logic [31:0]     value_reg;
    logic [7:0]      bytes_reg [udg_pkg::FRAME_BYTES];

    logic            s_fire;
    logic            m_fire;
    logic            xfer;
    logic [7:0]      frame [udg_pkg::FRAME_BYTES];
    logic [7:0]      read_crc;

    udg_pkg::rx_ctrl_t   rx_ctrl;
    udg_pkg::rx_result_t rx_res;

    //------------------------------------------------------------------
    // config port, always ready
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg    <= udg_pkg::SYNC_RESET;
            timeout_reg <= udg_pkg::TIMEOUT_RESET;
            limit_reg   <= udg_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                udg_pkg::CFG_SYNC:    sync_reg    <= pwdata[7:0];
                udg_pkg::CFG_TIMEOUT: timeout_reg <= pwdata[7:0];
                udg_pkg::CFG_LIMIT:   limit_reg   <= pwdata[5:0];
                default:              sync_reg    <= sync_reg;   // unmapped, ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            udg_pkg::CFG_SYNC:    prdata = {24'd0, sync_reg};
            udg_pkg::CFG_TIMEOUT: prdata = {24'd0, timeout_reg};
            udg_pkg::CFG_LIMIT:   prdata = {26'd0, limit_reg};
            default:              prdata = 32'd0;
        endcase
    end

    //------------------------------------------------------------------
    // handshakes
    //------------------------------------------------------------------
    assign m_fire   = m_tvalid && m_tready;
    // input register hands over when the buffer is empty or its last item leaves now
    assign xfer     = in_valid_reg && ((cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && m_tready));
    assign s_tready = !in_valid_reg || xfer;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next = s_fire ? 1'b1 : (xfer ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_func_reg <= udg_pkg::func_t'(s_tuser);
            in_node_reg <= s_tdata[1:0];
            in_reg_reg  <= s_tdata[8:2];
            in_wval_reg <= s_tdata[40:9];
            in_rxb_reg  <= s_tdata[48:41];
        end
    end

    //------------------------------------------------------------------
    // reception tracking, stepped once per item at hand-over
    //------------------------------------------------------------------
    assign rx_ctrl.step = xfer;
    assign rx_ctrl.func = in_func_reg;

    udg_rx u_rx (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (rx_ctrl),
        .reg_addr         (in_reg_reg),
        .rx_byte          (in_rxb_reg),
        .sync_byte        (sync_reg),
        .reply_timeout_ms (timeout_reg),
        .rx_byte_limit    (limit_reg),
        .result           (rx_res)
    );

    //------------------------------------------------------------------
    // request datagram builder
    //------------------------------------------------------------------
    assign read_crc = udg_pkg::crc8_byte(udg_pkg::crc8_byte(udg_pkg::crc8_byte(8'h00,
                          sync_reg), {6'd0, in_node_reg}), {1'b0, in_reg_reg});

    always_comb
    begin
        frame[0] = sync_reg;
        frame[1] = {6'd0, in_node_reg};
        if (in_func_reg == udg_pkg::FUNC_WRITE)
        begin
            // write: register with the write flag, value msb first, crc
            frame[2] = {1'b0, in_reg_reg} | udg_pkg::REG_WRITE_FLAG;
            frame[3] = in_wval_reg[31:24];
            frame[4] = in_wval_reg[23:16];
            frame[5] = in_wval_reg[15:8];
            frame[6] = in_wval_reg[7:0];
            frame[7] = udg_pkg::crc8_7({sync_reg, 6'd0, in_node_reg,
                                        {1'b0, in_reg_reg} | udg_pkg::REG_WRITE_FLAG,
                                        in_wval_reg});
        end
        else
        begin
            // read: register, crc, tail unused
            frame[2] = {1'b0, in_reg_reg};
            frame[3] = read_crc;
            frame[4] = 8'd0;
            frame[5] = 8'd0;
            frame[6] = 8'd0;
            frame[7] = 8'd0;
        end
    end

    //------------------------------------------------------------------
    // frame buffer
    //------------------------------------------------------------------
    always_comb
    begin
        cnt_next = cnt_reg;
        if (xfer)
        begin
            unique case (in_func_reg)
                udg_pkg::FUNC_WRITE:                      cnt_next = udg_pkg::WRITE_LEN;
                udg_pkg::FUNC_READ:                       cnt_next = udg_pkg::READ_LEN;
                udg_pkg::FUNC_RX_BYTE, udg_pkg::FUNC_TICK: cnt_next = rx_res.done ? 4'd1 : 4'd0;
                default:                                  cnt_next = 4'd0;
            endcase
        end
        else if (m_fire)
        begin
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            if ((in_func_reg == udg_pkg::FUNC_WRITE) || (in_func_reg == udg_pkg::FUNC_READ))
            begin
                kind_reg   <= 1'b0;
                status_reg <= udg_pkg::ST_OK;
                value_reg  <= 32'd0;
                for (int i = 0; i < udg_pkg::FRAME_BYTES; i++)
                    bytes_reg[i] <= frame[i];
            end
            else
            begin
                // completion carries no transmit byte
                kind_reg   <= 1'b1;
                status_reg <= rx_res.status;
                value_reg  <= rx_res.value;
                for (int i = 0; i < udg_pkg::FRAME_BYTES; i++)
                    bytes_reg[i] <= 8'd0;
            end
        end
        else if (m_fire)
        begin
            for (int i = 0; i < udg_pkg::FRAME_BYTES - 1; i++)
                bytes_reg[i] <= bytes_reg[i+1];
            bytes_reg[udg_pkg::FRAME_BYTES-1] <= 8'd0;
        end
    end

    assign m_tvalid = (cnt_reg != 4'd0);
    assign m_tuser  = kind_reg;
    assign m_tlast  = !kind_reg && (cnt_reg == 4'd1);
    assign m_tdata  = {6'd0, value_reg, status_reg, bytes_reg[0]};

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= udg_pkg::WRITE_LEN)
        else $error("frame buffer count out of range");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (cnt_reg == 4'd1))
        else $error("completion is not a single item");

    a_write_load: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && (in_func_reg == udg_pkg::FUNC_WRITE))
            |=> ((cnt_reg == udg_pkg::WRITE_LEN) && !kind_reg))
        else $error("write request did not load a full datagram");

endmodule

[dv/udg_datagram_checker.sv]
package udg_tb_pkg;

    import udg_pkg::*;

    localparam logic [7:0] DG_POLY = 8'h07;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        status_t     status;
        logic [31:0] value;
    } dg_result_t;

    // crc8 over the first n bytes of msg, byte 0 in the low bits, each byte lsb first
    function automatic logic [7:0] frame_crc(input logic [63:0] msg, input int n);
        logic [7:0] crc;
        logic [7:0] cur;
        logic       fb;
        crc = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            cur = msg[8*i +: 8];
            for (int b = 0; b < 8; b++)
            begin
                fb  = crc[7] ^ cur[b];
                crc = {crc[6:0], 1'b0} ^ (fb ? DG_POLY : 8'h00);
            end
        end
        return crc;
    endfunction

endpackage

module udg_datagram_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_results,
    output int          tx_byte_count,
    output int          ok_count,
    output int          crc_count,
    output int          frame_count,
    output int          timeout_count
);

    import udg_pkg::*;
    import udg_tb_pkg::*;

    logic [7:0]  cfg_sync;
    logic [7:0]  cfg_timeout;
    logic [5:0]  cfg_limit;

    logic [63:0] rx_shift;
    logic [5:0]  rx_seen;
    logic [7:0]  ms_elapsed;
    logic [6:0]  read_reg;
    logic        reply_armed;

    dg_result_t  expected_q[$];
    dg_result_t  want;

    task automatic finish_read(input status_t st, input logic [31:0] value);
        dg_result_t r;
        r.kind    = 1'b1;
        r.tx_byte = 8'h00;
        r.last    = 1'b0;
        r.status  = st;
        r.value   = value;
        expected_q.push_back(r);
        reply_armed = 1'b0;
        case (st)
            ST_OK:    ok_count++;
            ST_CRC:   crc_count++;
            ST_FRAME: frame_count++;
            default:  timeout_count++;
        endcase
    endtask

    task automatic predict_item(input logic [1:0] fn_bits, input logic [55:0] d);
        logic [1:0]  node;
        logic [6:0]  rg;
        logic [31:0] wval;
        logic [7:0]  rxb;
        logic [63:0] msg;
        logic [63:0] win;
        logic [6:0]  lim;
        logic        matched;
        int          n;
        dg_result_t  r;
        node = d[1:0];
        rg   = d[8:2];
        wval = d[40:9];
        rxb  = d[48:41];
        case (func_t'(fn_bits))
            FUNC_WRITE, FUNC_READ:
            begin
                // any request drops reception first
                rx_shift    = 64'd0;
                rx_seen     = 6'd0;
                ms_elapsed  = 8'd0;
                reply_armed = 1'b0;
                msg         = 64'd0;
                msg[7:0]    = cfg_sync;
                msg[15:8]   = {6'd0, node};
                if (fn_bits == FUNC_WRITE)
                begin
                    msg[23:16] = {1'b0, rg} | REG_WRITE_FLAG;
                    msg[31:24] = wval[31:24];
                    msg[39:32] = wval[23:16];
                    msg[47:40] = wval[15:8];
                    msg[55:48] = wval[7:0];
                    msg[63:56] = frame_crc(msg, 7);
                    n = 8;
                end
                else
                begin
                    msg[23:16]  = {1'b0, rg};
                    msg[31:24]  = frame_crc(msg, 3);
                    n           = 4;
                    read_reg    = rg;
                    reply_armed = 1'b1;
                end
                for (int i = 0; i < n; i++)
                begin
                    r.kind    = 1'b0;
                    r.tx_byte = msg[8*i +: 8];
                    r.last    = (i == n - 1);
                    r.status  = ST_OK;
                    r.value   = 32'd0;
                    expected_q.push_back(r);
                end
                tx_byte_count += n;
            end
            FUNC_RX_BYTE:
            begin
                if (reply_armed)
                begin
                    rx_shift = {rx_shift[55:0], rxb};
                    rx_seen  = rx_seen + 6'd1;
                    matched  = 1'b0;
                    if (rx_seen >= 6'd8)
                    begin
                        // oldest byte of the window goes to the low bits
                        for (int i = 0; i < 8; i++)
                            win[8*i +: 8] = rx_shift[8*(7-i) +: 8];
                        if (win[7:0] == cfg_sync && win[15:8] == REPLY_ADDR
                            && win[22:16] == read_reg)
                        begin
                            matched = 1'b1;
                            if (frame_crc(win, 7) != win[63:56])
                                finish_read(ST_CRC, 32'd0);
                            else
                                finish_read(ST_OK, {win[31:24], win[39:32],
                                                    win[47:40], win[55:48]});
                        end
                    end
                    lim = {1'b0, cfg_limit};
                    if (lim < RX_MIN_BYTES)
                        lim = RX_MIN_BYTES;
                    if (lim > RX_MAX_BYTES)
                        lim = RX_MAX_BYTES;
                    if (!matched && {1'b0, rx_seen} >= lim)
                        finish_read(ST_FRAME, 32'd0);
                end
            end
            default:
            begin
                if (reply_armed)
                begin
                    if (ms_elapsed != TICK_SAT)
                        ms_elapsed = ms_elapsed + 8'd1;
                    if (ms_elapsed >= cfg_timeout)
                    begin
                        if (rx_seen == 6'd0)
                            finish_read(ST_TIMEOUT, 32'd0);
                        else
                            finish_read(ST_FRAME, 32'd0);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sync    = SYNC_RESET;
            cfg_timeout = TIMEOUT_RESET;
            cfg_limit   = LIMIT_RESET;
            rx_shift    = 64'd0;
            rx_seen     = 6'd0;
            ms_elapsed  = 8'd0;
            read_reg    = 7'd0;
            reply_armed = 1'b0;
            expected_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d data %h", m_tuser, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind expected %0d actual %0d", want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[7:0] !== want.tx_byte)
                    begin
                        $error("tx_byte expected %h actual %h", want.tx_byte, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last expected %0d actual %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tdata[9:8] !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, m_tdata[9:8]);
                        mismatch_count++;
                    end
                    if (m_tdata[41:10] !== want.value)
                    begin
                        $error("read_value expected %h actual %h", want.value, m_tdata[41:10]);
                        mismatch_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    CFG_SYNC:    cfg_sync    = pwdata[7:0];
                    CFG_TIMEOUT: cfg_timeout = pwdata[7:0];
                    CFG_LIMIT:   cfg_limit   = pwdata[5:0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata);
            pending_results <= expected_q.size();
        end
    end

endmodule

[dv/tb_uart_register_datagram_engine_core.sv]
module tb_uart_register_datagram_engine_core;

    import udg_pkg::*;

    // generous bound: every item at 8 results with the receiver stalling, plus the hold-off
    localparam int CYCLE_LIMIT = 400000;
    // long receiver hold-off so the block backs up into its input
    localparam int HOLD_CYCLES = 300;
    // counted items per random phase
    localparam int PHASE_ITEMS = 45;

    logic        clk;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // node_addr[1:0], reg_addr[8:2], write_value[40:9],
                            // rx_byte[48:41], zero fill [55:49]
    logic [1:0]  s_tuser;   // func[1:0]

    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // tx_byte[7:0], status[9:8], read_value[41:10], zero fill [47:42]
    logic        m_tuser;   // kind
    logic        m_tlast;   // last

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int pending_results;
    int tx_byte_count;
    int ok_count;
    int crc_count;
    int frame_count;
    int timeout_count;

    int cycle_count;
    int items_offered;
    int phases_run;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    // settings currently loaded, needed to build matching replies
    logic [7:0] cur_sync;
    logic [7:0] cur_timeout;
    logic [5:0] cur_limit;

    uart_register_datagram_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    udg_datagram_checker datagram_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .tx_byte_count   (tx_byte_count),
        .ok_count        (ok_count),
        .crc_count       (crc_count),
        .frame_count     (frame_count),
        .timeout_count   (timeout_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uart_register_datagram_engine_core test failed");
            $finish;
        end
    end

    // result side: random stalls per phase, plus the long hold-off when asked for
    initial
    begin : ready_driver
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // offer one item and wait for it to be taken; valid stays high for a following item
    task automatic offer(input func_t fn, input logic [1:0] node, input logic [6:0] rg,
                         input logic [31:0] wv, input logic [7:0] rb, input bit counted);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'd0, rb, wv, rg, node};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (counted)
            items_offered++;
    endtask

    // unused fields are randomized so every input bit outside the zero fill toggles
    task automatic send_request(input func_t fn, input logic [1:0] node, input logic [6:0] rg,
                                input logic [31:0] wv);
        offer(fn, node, rg, wv, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer(FUNC_RX_BYTE, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom,
              b, 1'b1);
    endtask

    task automatic send_tick();
        offer(FUNC_TICK, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom,
              8'($urandom_range(0, 255)), 1'b1);
    endtask

    // crc8 of the first seven bytes, byte 0 in the low bits, each byte lsb first
    function automatic logic [7:0] reply_crc(input logic [63:0] msg);
        logic [7:0] crc;
        logic [7:0] cur;
        crc = 8'h00;
        for (int i = 0; i < 7; i++)
        begin
            cur = msg[8*i +: 8];
            for (int b = 0; b < 8; b++)
            begin
                if (crc[7] ^ cur[b])
                    crc = {crc[6:0], 1'b0} ^ CRC_POLY;
                else
                    crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // well-formed reply for the current sync byte, byte 0 in the low bits
    function automatic logic [63:0] reply_frame(input logic [7:0] reg_byte,
                                                input logic [31:0] value);
        logic [63:0] msg;
        msg = {8'h00, value[7:0], value[15:8], value[23:16], value[31:24],
               reg_byte, REPLY_ADDR, cur_sync};
        msg[63:56] = reply_crc(msg);
        return msg;
    endfunction

    task automatic send_frame(input logic [63:0] msg);
        for (int i = 0; i < 8; i++)
            send_byte(msg[8*i +: 8]);
    endtask

    // stop offering, wait for every expected result, then let a byte or tick in flight settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // setup cycle, access cycle, then idle so back-to-back writes never collide
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // junk in the upper bits checks that only the register width is kept
    task automatic set_config(input logic [7:0] sync, input logic [7:0] tmo,
                              input logic [5:0] lim);
        apb_write(CFG_SYNC, ($urandom & 32'hFFFF_FF00) | {24'd0, sync});
        apb_write(CFG_TIMEOUT, ($urandom & 32'hFFFF_FF00) | {24'd0, tmo});
        apb_write(CFG_LIMIT, ($urandom & 32'hFFFF_FFC0) | {26'd0, lim});
        cur_sync    = sync;
        cur_timeout = tmo;
        cur_limit   = lim;
    endtask

    // one random exchange, mostly read requests followed by a reply, garbage bytes or ticks
    task automatic random_datagram();
        int          pick;
        int          n;
        int          k;
        int          lim_eff;
        logic [6:0]  rg;
        logic        reg_top;
        logic [63:0] msg;
        pick = $urandom_range(0, 99);
        rg   = 7'($urandom_range(0, 127));
        if (pick < 20)
            send_request(FUNC_WRITE, 2'($urandom_range(0, 3)), rg, $urandom);
        else if (pick < 55)
        begin
            send_request(FUNC_READ, 2'($urandom_range(0, 3)), rg, $urandom);
            // some line noise ahead of the reply shifts the window
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            reg_top = 1'($urandom_range(0, 1));
            msg     = reply_frame({reg_top, rg}, $urandom);
            // a single flipped bit gives a crc error or a reply that never matches
            if ($urandom_range(0, 3) == 0)
            begin
                k      = $urandom_range(0, 63);
                msg[k] = ~msg[k];
            end
            send_frame(msg);
            if ($urandom_range(0, 2) == 0)
            begin
                send_tick();
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        else if (pick < 70)
        begin
            // garbage up to and past the byte limit
            lim_eff = cur_limit;
            if (lim_eff < 8)
                lim_eff = 8;
            if (lim_eff > RX_BUFFER_BYTES)
                lim_eff = RX_BUFFER_BYTES;
            send_request(FUNC_READ, 2'($urandom_range(0, 3)), rg, $urandom);
            n = $urandom_range(1, lim_eff + 2);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 85)
        begin
            // ticks toward the reply timeout, with or without bytes first
            send_request(FUNC_READ, 2'($urandom_range(0, 3)), rg, $urandom);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
            if (cur_timeout < 6)
                n = $urandom_range(1, cur_timeout + 1);
            else
                n = $urandom_range(1, 4);
            repeat (n) send_tick();
        end
        else
        begin
            // stray bytes and ticks, usually with reception idle
            repeat ($urandom_range(1, 3))
                offer(func_t'($urandom_range(2, 3)), 2'($urandom_range(0, 3)),
                      7'($urandom_range(0, 127)), $urandom, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic run_phase(input logic [7:0] sync, input logic [7:0] tmo, input logic [5:0] lim,
                             input int send_pct, input int recv_pct, input bit squeeze);
        int first;
        set_config(sync, tmo, lim);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        first = items_offered;
        if (squeeze)
        begin
            // receiver holds off while write requests keep coming
            hold_req <= ~hold_req;
            repeat (16) send_request(FUNC_WRITE, 2'($urandom_range(0, 3)),
                                     7'($urandom_range(0, 127)), $urandom);
        end
        while (items_offered - first < PHASE_ITEMS)
            random_datagram();
        drain();
        phases_run++;
    endtask

    initial
    begin : stimulus
        logic [63:0] msg;
        s_tvalid      = 1'b0;
        s_tdata       = 56'd0;
        s_tuser       = FUNC_WRITE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 4'd0;
        pwdata        = 32'd0;
        send_idle_pct = 0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: short timeout and the smallest byte limit
        set_config(SYNC_RESET, 8'd2, 6'd8);
        send_request(FUNC_WRITE, 2'd0, 7'd0, 32'h0000_0000);
        send_request(FUNC_WRITE, 2'd3, 7'd127, 32'hFFFF_FFFF);
        // byte and tick with reception idle are dropped
        send_byte(8'hFF);
        send_tick();
        // a second read while the first is armed restarts reception
        send_request(FUNC_READ, 2'd2, 7'h11, 32'h0);
        send_request(FUNC_READ, 2'd1, 7'h22, 32'h0);
        // good reply with bit 7 set in the register byte, matched on the limit byte
        send_frame(reply_frame(8'hA2, 32'h89AB_CDEF));
        // reply with a bad crc
        send_request(FUNC_READ, 2'd3, 7'd127, 32'h0);
        msg = reply_frame(8'h7F, 32'h0123_4567);
        msg[63:56] = ~msg[63:56];
        send_frame(msg);
        // timeout after a byte arrived is a frame error
        send_request(FUNC_READ, 2'd0, 7'd0, 32'h0);
        send_byte(8'h00);
        send_tick();
        send_tick();
        // timeout with nothing received
        send_request(FUNC_READ, 2'd0, 7'd5, 32'h0);
        send_tick();
        send_tick();
        drain();

        // random phases: reset values, extremes, then mixed settings
        run_phase(SYNC_RESET, TIMEOUT_RESET, LIMIT_RESET, 0, 0, 1'b1);
        run_phase(8'h00, 8'd0, 6'd0, 52, 0, 1'b0);
        run_phase(8'hFF, 8'd255, 6'd63, 0, 52, 1'b0);
        run_phase(8'hA5, 8'd1, 6'd8, 25, 25, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'd3, 6'd12, 0, 0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
                  6'($urandom_range(8, 32)), 52, 0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'd2, 6'd40, 0, 52, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
                  6'($urandom_range(0, 63)), 25, 25, 1'b0);

        $display("ran %0d items over %0d register settings, %0d datagram bytes predicted",
                 items_offered, phases_run + 1, tx_byte_count);
        $display("read outcomes: %0d ok, %0d crc error, %0d frame error, %0d timeout",
                 ok_count, crc_count, frame_count, timeout_count);
        if (mismatch_count == 0)
            $display("uart_register_datagram_engine_core test passed");
        else
            $display("uart_register_datagram_engine_core test failed");
        $finish;
    end

endmodule
